/* sv/uart8250_pkg.sv */
// Shared types, codes and interrupt/modem helper functions for the 8250 UART register model.
// No dependencies; imported by every other file except uart8250_checker.
package uart8250_pkg;

    // Request kinds carried on the input channel's tuser.
    typedef enum logic [2:0] {
        ACT_READ  = 3'd0,
        ACT_WRITE = 3'd1,
        ACT_TICK  = 3'd2,
        ACT_PUSH  = 3'd3,
        ACT_PULL  = 3'd4,
        ACT_DSR   = 3'd5,
        ACT_CTS   = 3'd6,
        ACT_DCD   = 3'd7
    } action_t;

    // Register offsets.
    localparam logic [2:0] REG_DATA = 3'd0;
    localparam logic [2:0] REG_IER  = 3'd1;
    localparam logic [2:0] REG_IIR  = 3'd2;
    localparam logic [2:0] REG_LCR  = 3'd3;
    localparam logic [2:0] REG_MCR  = 3'd4;
    localparam logic [2:0] REG_LSR  = 3'd5;
    localparam logic [2:0] REG_MSR  = 3'd6;
    localparam logic [2:0] REG_SCR  = 3'd7;

    // Interrupt identification codes and pending-source bits.
    localparam logic [2:0] IIR_NONE = 3'd1;
    localparam logic [2:0] IIR_THRE = 3'd2;
    localparam logic [2:0] IIR_RDA  = 3'd4;
    localparam logic [1:0] INT_NONE = 2'b00;
    localparam logic [1:0] INT_RX   = 2'b01;
    localparam logic [1:0] INT_TX   = 2'b10;

    // Modem status bits.
    localparam logic [7:0] MSR_DCTS       = 8'h01;
    localparam logic [7:0] MSR_DDSR       = 8'h02;
    localparam logic [7:0] MSR_DDCD       = 8'h08;
    localparam logic [7:0] MSR_CTS        = 8'h10;
    localparam logic [7:0] MSR_DSR        = 8'h20;
    localparam logic [7:0] MSR_RI         = 8'h40;
    localparam logic [7:0] MSR_DCD        = 8'h80;
    localparam logic [7:0] MSR_DELTA_MASK = 8'h0f;
    localparam logic [7:0] MSR_LINE_MASK  = 8'hf0;

    localparam logic [7:0] LSR_RESET = 8'h60;

    typedef struct packed {
        action_t    action;
        logic [2:0] addr;
        logic [7:0] wdata;
        logic       line_level;
    } uart_item_t;

    typedef struct packed {
        logic [7:0]  rdata;
        logic        queue_fail;
        logic [7:0]  tx_byte;
        logic        irq_raise;
        logic        rx_loaded;
        logic        tx_sent;
        logic        setup_changed;
        logic        dtr;
        logic        rts;
        logic [15:0] divisor_out;
        logic [7:0]  line_control_out;
    } uart_result_t;

    // Architectural registers of the UART, apart from the byte queues.
    typedef struct packed {
        logic [7:0]  rx_holding;
        logic        rx_holding_valid;
        logic [7:0]  tx_holding;
        logic        tx_holding_valid;
        logic [3:0]  int_enable;
        logic [2:0]  int_ident;
        logic [1:0]  int_pending;
        logic [7:0]  line_control;
        logic [7:0]  line_status;
        logic [4:0]  modem_control;
        logic [7:0]  modem_status;
        logic [7:0]  scratch;
        logic [15:0] baud_divisor;
    } uart_regs_t;

    localparam uart_regs_t REGS_RESET = '{
        rx_holding:       8'h00,
        rx_holding_valid: 1'b0,
        tx_holding:       8'h00,
        tx_holding_valid: 1'b0,
        int_enable:       4'h0,
        int_ident:        IIR_NONE,
        int_pending:      INT_NONE,
        line_control:     8'h00,
        line_status:      LSR_RESET,
        modem_control:    5'h00,
        modem_status:     8'h00,
        scratch:          8'h00,
        baud_divisor:     16'h0000
    };

    typedef struct packed {
        logic [1:0] pending;
        logic [2:0] ident;
        logic       raise;
    } int_upd_t;

    typedef struct packed {
        logic [4:0] mcr;
        logic [7:0] msr;
        logic       setup;
    } mcr_upd_t;

    // Adds sources to the pending set and promotes the identification code.
    function automatic int_upd_t int_set(logic [1:0] pending, logic [3:0] enable,
                                         logic [2:0] ident, logic [1:0] src);
        int_upd_t   u;
        logic [1:0] act;
        u.pending = pending | src;
        u.ident   = ident;
        u.raise   = 1'b0;
        act       = u.pending & enable[1:0];
        if (act[0] && (ident < IIR_RDA)) begin
            u.ident = IIR_RDA;
            u.raise = 1'b1;
        end else if (act[1] && (ident < IIR_THRE)) begin
            u.ident = IIR_THRE;
            u.raise = 1'b1;
        end
        return u;
    endfunction

    // Drops sources, releases a matching identification, then re-evaluates.
    function automatic int_upd_t int_clr(logic [1:0] pending, logic [3:0] enable,
                                         logic [2:0] ident, logic [1:0] src);
        logic [1:0] p;
        logic [2:0] id;
        p  = pending & ~src;
        id = ident;
        if (src[0] && (id == IIR_RDA)) begin
            id = IIR_NONE;
        end
        if (src[1] && (id == IIR_THRE)) begin
            id = IIR_NONE;
        end
        return int_set(p, enable, id, INT_NONE);
    endfunction

    // New level on one modem input; a change sets its delta bit.
    function automatic logic [7:0] set_line(logic [7:0] msr, logic [7:0] line_bit,
                                            logic [7:0] delta_bit, logic level);
        logic [7:0] n;
        n = level ? (msr | line_bit) : (msr & ~line_bit);
        if (((msr ^ n) & line_bit) != 8'h00) begin
            n = n | delta_bit;
        end
        return n;
    endfunction

    // Modem control write, including entry to and exit from loopback.
    function automatic mcr_upd_t write_mcr(logic [4:0] mcr, logic [7:0] msr, logic [7:0] v);
        mcr_upd_t   u;
        logic [7:0] o;
        u.msr   = msr;
        u.setup = 1'b0;
        if (mcr[4] && !v[4]) begin
            o       = u.msr;
            u.msr   = u.msr & MSR_DELTA_MASK;
            u.msr   = u.msr | (((o ^ u.msr) & ~(u.msr & MSR_RI)) >> 4);
            u.setup = 1'b1;
        end
        u.mcr = v[4:0];
        if (v[4]) begin
            o        = u.msr;
            u.msr    = u.msr & MSR_DELTA_MASK;
            u.msr[4] = v[1];
            u.msr[5] = v[0];
            u.msr[6] = v[2];
            u.msr[7] = v[3];
            u.msr    = u.msr | (((o ^ u.msr) & ~(u.msr & MSR_RI)) >> 4);
            u.setup  = 1'b1;
        end
        return u;
    endfunction

endpackage

/* sv/uart8250_state.sv */
// State of the 8250 UART model: register set, queue pointers and the two byte rings.
// Depends on uart8250_pkg; written by the top level once per processed request.
module uart8250_state
    import uart8250_pkg::*;
#(
    parameter int QUEUE_SLOTS = 2,
    localparam int QW = $clog2(QUEUE_SLOTS)
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          commit,
    input  uart_regs_t    regs_next,
    input  logic [QW-1:0] rx_head_next,
    input  logic [QW-1:0] rx_tail_next,
    input  logic [QW-1:0] tx_head_next,
    input  logic [QW-1:0] tx_tail_next,
    input  logic          rx_wr,
    input  logic [QW-1:0] rx_wr_idx,
    input  logic [7:0]    rx_wr_data,
    input  logic          tx_wr,
    input  logic [QW-1:0] tx_wr_idx,
    input  logic [7:0]    tx_wr_data,
    output uart_regs_t    regs,
    output logic [QW-1:0] rx_head,
    output logic [QW-1:0] rx_tail,
    output logic [QW-1:0] tx_head,
    output logic [QW-1:0] tx_tail,
    output logic [7:0]    rx_head_data,
    output logic [7:0]    tx_head_data
);

    uart_regs_t    regs_reg;
    logic [QW-1:0] rx_head_reg, rx_tail_reg, tx_head_reg, tx_tail_reg;
    logic [7:0]    rx_ring_reg [QUEUE_SLOTS];
    logic [7:0]    tx_ring_reg [QUEUE_SLOTS];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            regs_reg    <= REGS_RESET;
            rx_head_reg <= '0;
            rx_tail_reg <= '0;
            tx_head_reg <= '0;
            tx_tail_reg <= '0;
        end else if (commit) begin
            regs_reg    <= regs_next;
            rx_head_reg <= rx_head_next;
            rx_tail_reg <= rx_tail_next;
            tx_head_reg <= tx_head_next;
            tx_tail_reg <= tx_tail_next;
        end
    end

    // Ring entries carry no reset; pointers keep unwritten slots from being read.
    always_ff @(posedge aclk) begin
        if (commit && rx_wr) begin
            rx_ring_reg[rx_wr_idx] <= rx_wr_data;
        end
        if (commit && tx_wr) begin
            tx_ring_reg[tx_wr_idx] <= tx_wr_data;
        end
    end

    assign regs         = regs_reg;
    assign rx_head      = rx_head_reg;
    assign rx_tail      = rx_tail_reg;
    assign tx_head      = tx_head_reg;
    assign tx_tail      = tx_tail_reg;
    assign rx_head_data = rx_ring_reg[rx_head_reg];
    assign tx_head_data = tx_ring_reg[tx_head_reg];

endmodule

/* sv/uart8250_step.sv */
// Next-state and result logic for one request of the 8250 UART model.
// Depends on uart8250_pkg; purely combinational, fed from uart8250_state.
module uart8250_step
    import uart8250_pkg::*;
#(
    parameter int QUEUE_SLOTS = 2,
    localparam int QW = $clog2(QUEUE_SLOTS)
) (
    input  uart_item_t    item,
    input  uart_regs_t    regs,
    input  logic [QW-1:0] rx_head,
    input  logic [QW-1:0] rx_tail,
    input  logic [QW-1:0] tx_head,
    input  logic [QW-1:0] tx_tail,
    input  logic [7:0]    rx_head_data,
    input  logic [7:0]    tx_head_data,
    output uart_regs_t    regs_next,
    output logic [QW-1:0] rx_head_next,
    output logic [QW-1:0] rx_tail_next,
    output logic [QW-1:0] tx_head_next,
    output logic [QW-1:0] tx_tail_next,
    output logic          rx_wr,
    output logic [QW-1:0] rx_wr_idx,
    output logic [7:0]    rx_wr_data,
    output logic          tx_wr,
    output logic [QW-1:0] tx_wr_idx,
    output logic [7:0]    tx_wr_data,
    output uart_result_t  result
);

    localparam logic [QW-1:0] LAST_IDX = QW'(QUEUE_SLOTS - 1);

    typedef struct packed {
        uart_regs_t    r;
        logic [QW-1:0] rx_hd;
        logic [QW-1:0] rx_tl;
        logic [QW-1:0] tx_hd;
        logic [QW-1:0] tx_tl;
        logic          rx_wr;
        logic [QW-1:0] rx_wr_idx;
        logic [7:0]    rx_wr_data;
        logic          tx_wr;
        logic [QW-1:0] tx_wr_idx;
        logic [7:0]    tx_wr_data;
        logic          f_irq;
        logic          f_rxl;
        logic          f_txs;
        logic          f_setup;
    } work_t;

    function automatic logic [QW-1:0] qnext(logic [QW-1:0] i);
        return (i == LAST_IDX) ? '0 : i + 1'b1;
    endfunction

    function automatic work_t do_int_set(work_t w, logic [1:0] src);
        int_upd_t u;
        u = int_set(w.r.int_pending, w.r.int_enable, w.r.int_ident, src);
        w.r.int_pending = u.pending;
        w.r.int_ident   = u.ident;
        w.f_irq         = w.f_irq | (u.raise & w.r.modem_control[3]);
        return w;
    endfunction

    function automatic work_t do_int_clr(work_t w, logic [1:0] src);
        int_upd_t u;
        u = int_clr(w.r.int_pending, w.r.int_enable, w.r.int_ident, src);
        w.r.int_pending = u.pending;
        w.r.int_ident   = u.ident;
        w.f_irq         = w.f_irq | (u.raise & w.r.modem_control[3]);
        return w;
    endfunction

    // Moves the oldest received byte into the holding register. A byte that was
    // pushed earlier in the same request is taken from the write path, since the
    // ring itself is only written at the end of the cycle.
    function automatic work_t do_check_rx(work_t w, logic [7:0] head_data);
        if (!w.r.rx_holding_valid && (w.rx_hd != w.rx_tl)) begin
            w.r.rx_holding = (w.rx_wr && (w.rx_wr_idx == w.rx_hd)) ? w.rx_wr_data
                                                                     : head_data;
            w.rx_hd              = qnext(w.rx_hd);
            w.r.rx_holding_valid = 1'b1;
            w.r.line_status[0]   = 1'b1;
            w.f_rxl              = 1'b1;
            w = do_int_set(w, INT_RX);
        end
        return w;
    endfunction

    // Moves the transmit holding byte to the line queue (it stays held while that queue
    // is full), or back into the receive queue in loopback (dropped there when that queue is full).
    function automatic work_t do_check_tx(work_t w, logic [7:0] head_data);
        logic loop;
        logic done;
        loop = w.r.modem_control[4];
        done = 1'b0;
        if (w.r.tx_holding_valid) begin
            done = 1'b1;
            if (loop) begin
                if (qnext(w.rx_tl) != w.rx_hd) begin
                    w.rx_wr      = 1'b1;
                    w.rx_wr_idx  = w.rx_tl;
                    w.rx_wr_data = w.r.tx_holding;
                    w.rx_tl      = qnext(w.rx_tl);
                end
            end else if (qnext(w.tx_tl) == w.tx_hd) begin
                done = 1'b0;
            end else begin
                w.tx_wr      = 1'b1;
                w.tx_wr_idx  = w.tx_tl;
                w.tx_wr_data = w.r.tx_holding;
                w.tx_tl      = qnext(w.tx_tl);
            end
        end
        if (done) begin
            w.r.tx_holding_valid = 1'b0;
            w.r.line_status[5]   = 1'b1;
            if (loop) begin
                w = do_check_rx(w, head_data);
            end else begin
                w.f_txs = 1'b1;
            end
            w = do_int_set(w, INT_TX);
        end
        return w;
    endfunction

    work_t      w;
    mcr_upd_t   mu;
    logic       dlab;
    logic [7:0] rdata;
    logic       fail;
    logic [7:0] txb;

    always_comb begin
        w            = '0;
        w.r          = regs;
        w.rx_hd      = rx_head;
        w.rx_tl      = rx_tail;
        w.tx_hd      = tx_head;
        w.tx_tl      = tx_tail;
        mu           = '0;
        rdata        = 8'h00;
        fail         = 1'b0;
        txb          = 8'h00;
        dlab         = regs.line_control[7];
        case (item.action)
            ACT_READ: begin
                case (item.addr)
                    REG_DATA: begin
                        if (dlab) begin
                            rdata = w.r.baud_divisor[7:0];
                        end else begin
                            rdata                = w.r.rx_holding;
                            w.r.rx_holding_valid = 1'b0;
                            w.r.line_status[0]   = 1'b0;
                            w = do_int_clr(w, INT_RX);
                            w = do_check_rx(w, rx_head_data);
                        end
                    end
                    REG_IER: begin
                        rdata = dlab ? w.r.baud_divisor[15:8] : {4'h0, w.r.int_enable};
                    end
                    REG_IIR: begin
                        rdata = {5'h00, w.r.int_ident};
                        w = do_int_clr(w, INT_TX);
                    end
                    REG_LCR: rdata = w.r.line_control;
                    REG_MCR: rdata = {3'b000, w.r.modem_control};
                    REG_LSR: rdata = w.r.line_status;
                    REG_MSR: begin
                        rdata            = w.r.modem_status;
                        w.r.modem_status = w.r.modem_status & MSR_LINE_MASK;
                    end
                    default: rdata = w.r.scratch;
                endcase
            end
            ACT_WRITE: begin
                case (item.addr)
                    REG_DATA: begin
                        if (dlab) begin
                            w.r.baud_divisor[7:0] = item.wdata;
                            w.f_setup             = 1'b1;
                        end else begin
                            w.r.tx_holding       = item.wdata;
                            w.r.tx_holding_valid = 1'b1;
                            w.r.line_status[5]   = 1'b0;
                            w = do_int_clr(w, INT_TX);
                            w = do_check_tx(w, rx_head_data);
                        end
                    end
                    REG_IER: begin
                        if (dlab) begin
                            w.r.baud_divisor[15:8] = item.wdata;
                            w.f_setup              = 1'b1;
                        end else begin
                            w.r.int_enable = item.wdata[3:0];
                            w = do_int_set(w, {w.r.line_status[5], w.r.line_status[0]});
                        end
                    end
                    REG_LCR: begin
                        w.r.line_control = item.wdata;
                        w.f_setup        = 1'b1;
                    end
                    REG_MCR: begin
                        mu = write_mcr(w.r.modem_control, w.r.modem_status, item.wdata);
                        w.r.modem_control = mu.mcr;
                        w.r.modem_status  = mu.msr;
                        w.f_setup         = mu.setup;
                    end
                    REG_SCR: w.r.scratch = item.wdata;
                    default: begin
                        // Identification, line status and modem status are read only.
                    end
                endcase
            end
            ACT_TICK: begin
                w = do_check_rx(w, rx_head_data);
                w = do_check_tx(w, rx_head_data);
            end
            ACT_PUSH: begin
                if (qnext(w.rx_tl) == w.rx_hd) begin
                    fail = 1'b1;
                end else begin
                    w.rx_wr      = 1'b1;
                    w.rx_wr_idx  = w.rx_tl;
                    w.rx_wr_data = item.wdata;
                    w.rx_tl      = qnext(w.rx_tl);
                end
            end
            ACT_PULL: begin
                if (w.tx_hd == w.tx_tl) begin
                    fail = 1'b1;
                end else begin
                    txb     = tx_head_data;
                    w.tx_hd = qnext(w.tx_hd);
                end
            end
            ACT_DSR: w.r.modem_status = set_line(w.r.modem_status, MSR_DSR, MSR_DDSR,
                                                 item.line_level);
            ACT_CTS: w.r.modem_status = set_line(w.r.modem_status, MSR_CTS, MSR_DCTS,
                                                 item.line_level);
            default: w.r.modem_status = set_line(w.r.modem_status, MSR_DCD, MSR_DDCD,
                                                 item.line_level);
        endcase
    end

    assign regs_next    = w.r;
    assign rx_head_next = w.rx_hd;
    assign rx_tail_next = w.rx_tl;
    assign tx_head_next = w.tx_hd;
    assign tx_tail_next = w.tx_tl;
    assign rx_wr        = w.rx_wr;
    assign rx_wr_idx    = w.rx_wr_idx;
    assign rx_wr_data   = w.rx_wr_data;
    assign tx_wr        = w.tx_wr;
    assign tx_wr_idx    = w.tx_wr_idx;
    assign tx_wr_data   = w.tx_wr_data;

    always_comb begin
        result.rdata            = rdata;
        result.queue_fail       = fail;
        result.tx_byte          = txb;
        result.irq_raise        = w.f_irq;
        result.rx_loaded        = w.f_rxl;
        result.tx_sent          = w.f_txs;
        result.setup_changed    = w.f_setup;
        result.dtr              = w.r.modem_control[0];
        result.rts              = w.r.modem_control[1];
        result.divisor_out      = w.r.baud_divisor;
        result.line_control_out = w.r.line_control;
    end

endmodule

/* sv/uart_8250_register_model.sv */
// Top level of the 8250 UART register model: request register, state, step logic, result register.
// Depends on uart8250_pkg, uart8250_state and uart8250_step.
//
//  channel | direction | tdata fields (low bit first)                        | tuser
//  --------+-----------+------------------------------------------------------+--------
//  s_      | in        | addr[2:0], wdata[10:3], line_level[11], zero [15:12] | action
//  m_      | out       | rdata, queue_fail, tx_byte, irq_raise, rx_loaded,    | -
//          |           | tx_sent, setup_changed, dtr, rts, divisor_out,       |
//          |           | line_control_out, zero [47]                          |
//
// One request is accepted per cycle while the m_ side is not stalled; its result passes through
// the request register and then the result register. The single combinational step between the
// request register and the result register sets that rate: the UART state is updated in the
// same edge that loads the result, so the next request already sees it.
// A stalled result holds in the result register while one more request waits in
// the request register. aresetn (synchronous) clears all control state and the
// UART registers at once; the byte rings need no clearing pass.
module uart_8250_register_model
    import uart8250_pkg::*;
#(
    parameter int QUEUE_SLOTS = 2
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // addr[2:0], wdata[10:3], line_level[11], zero pad
    input  logic [2:0]  s_tuser,   // action[2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata    // rdata[7:0], queue_fail[8], tx_byte[16:9],
                                   // irq_raise[17], rx_loaded[18], tx_sent[19],
                                   // setup_changed[20], dtr[21], rts[22],
                                   // divisor_out[38:23], line_control_out[46:39], zero[47]
);

    localparam int QW = $clog2(QUEUE_SLOTS);

    // Request register.
    logic       in_valid_reg, in_valid_next;
    uart_item_t in_item_reg;
    // Result register.
    logic         out_valid_reg, out_valid_next;
    uart_result_t out_res_reg;

    logic         s_fire;
    logic         advance;
    uart_item_t   s_item;
    uart_result_t step_res;

    uart_regs_t    regs, regs_next;
    logic [QW-1:0] rx_head, rx_tail, tx_head, tx_tail;
    logic [QW-1:0] rx_head_next, rx_tail_next, tx_head_next, tx_tail_next;
    logic          rx_wr, tx_wr;
    logic [QW-1:0] rx_wr_idx, tx_wr_idx;
    logic [7:0]    rx_wr_data, tx_wr_data;
    logic [7:0]    rx_head_data, tx_head_data;

    // The held request is processed whenever the result register is free or being emptied.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_fire   = s_tvalid && s_tready;

    always_comb begin
        s_item.action     = action_t'(s_tuser);
        s_item.addr       = s_tdata[2:0];
        s_item.wdata      = s_tdata[10:3];
        s_item.line_level = s_tdata[11];
    end

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_fire) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_item_reg <= s_item;
        end
        if (advance) begin
            out_res_reg <= step_res;
        end
    end

    uart8250_state #(
        .QUEUE_SLOTS (QUEUE_SLOTS)
    ) u_state (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .commit       (advance),
        .regs_next    (regs_next),
        .rx_head_next (rx_head_next),
        .rx_tail_next (rx_tail_next),
        .tx_head_next (tx_head_next),
        .tx_tail_next (tx_tail_next),
        .rx_wr        (rx_wr),
        .rx_wr_idx    (rx_wr_idx),
        .rx_wr_data   (rx_wr_data),
        .tx_wr        (tx_wr),
        .tx_wr_idx    (tx_wr_idx),
        .tx_wr_data   (tx_wr_data),
        .regs         (regs),
        .rx_head      (rx_head),
        .rx_tail      (rx_tail),
        .tx_head      (tx_head),
        .tx_tail      (tx_tail),
        .rx_head_data (rx_head_data),
        .tx_head_data (tx_head_data)
    );

    uart8250_step #(
        .QUEUE_SLOTS (QUEUE_SLOTS)
    ) u_step (
        .item         (in_item_reg),
        .regs         (regs),
        .rx_head      (rx_head),
        .rx_tail      (rx_tail),
        .tx_head      (tx_head),
        .tx_tail      (tx_tail),
        .rx_head_data (rx_head_data),
        .tx_head_data (tx_head_data),
        .regs_next    (regs_next),
        .rx_head_next (rx_head_next),
        .rx_tail_next (rx_tail_next),
        .tx_head_next (tx_head_next),
        .tx_tail_next (tx_tail_next),
        .rx_wr        (rx_wr),
        .rx_wr_idx    (rx_wr_idx),
        .rx_wr_data   (rx_wr_data),
        .tx_wr        (tx_wr),
        .tx_wr_idx    (tx_wr_idx),
        .tx_wr_data   (tx_wr_data),
        .result       (step_res)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0,
                       out_res_reg.line_control_out,
                       out_res_reg.divisor_out,
                       out_res_reg.rts,
                       out_res_reg.dtr,
                       out_res_reg.setup_changed,
                       out_res_reg.tx_sent,
                       out_res_reg.rx_loaded,
                       out_res_reg.irq_raise,
                       out_res_reg.tx_byte,
                       out_res_reg.queue_fail,
                       out_res_reg.rdata};

endmodule

/* sv/uart8250_checker.sv */
// Port-level checks for the 8250 UART register model, and the bind that attaches them.
// Depends only on the ports of uart_8250_register_model.
module uart8250_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata
);

    // Reset empties the result register.
    a_reset_empties: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // A request is held off only while a result waits on a stalled output.
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && !s_tready) |-> (m_tvalid && !m_tready))
        else $error("request stalled without a waiting result");

    // A stalled result keeps its value.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result changed");

    // A queue failure comes only from a push or pull: no read data, no events.
    a_fail_alone: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[8]) |-> ((m_tdata[7:0] == 8'h00) && (m_tdata[16:9] == 8'h00)
                                      && (m_tdata[20:17] == 4'h0)))
        else $error("queue failure with other activity");

    // Loading the receive holding register and a setup change never share a request.
    a_load_vs_setup: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[18] && m_tdata[20]))
        else $error("rx load together with setup change");

endmodule

bind uart_8250_register_model uart8250_checker u_uart8250_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

/* test/uart8250_reply_checker.sv */
// Reply checker for the 8250 UART register model: predicts every reply from the accepted
// requests and compares it field by field. Depends on uart8250_pkg only.
module uart8250_reply_checker
    import uart8250_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [15:0] s_tdata,
    input  logic [2:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [47:0] m_tdata,
    output int          fail_count,
    output int          outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int QUEUE_DEPTH = 2;
    localparam logic [7:0] LSR_DR   = 8'h01;
    localparam logic [7:0] LSR_THRE = 8'h20;

    typedef struct packed {
        logic [7:0]  rdata;
        logic        queue_fail;
        logic [7:0]  tx_byte;
        logic        irq_raise;
        logic        rx_loaded;
        logic        tx_sent;
        logic        setup_changed;
        logic        dtr;
        logic        rts;
        logic [15:0] divisor;
        logic [7:0]  lcr;
    } uart_reply_t;

    uart_reply_t predicted_replies[$];
    int          reply_num;

    // Shadow copy of the UART registers and its two byte queues.
    logic [7:0]  rx_fifo[QUEUE_DEPTH];
    logic [7:0]  tx_fifo[QUEUE_DEPTH];
    int          rx_rd, rx_wr, tx_rd, tx_wr;
    logic [7:0]  rbr, thr;
    logic        rbr_full, thr_full;
    logic [3:0]  ier;
    logic [2:0]  iir;
    logic [1:0]  int_src;
    logic [7:0]  lcr, lsr, msr, scr;
    logic [4:0]  mcr;
    logic [15:0] divisor_latch;
    logic        irq_seen, rx_load_seen, tx_send_seen, setup_seen;

    function automatic int ring_next(int i);
        return (i + 1 >= QUEUE_DEPTH) ? 0 : i + 1;
    endfunction

    function automatic bit rx_enqueue(logic [7:0] v);
        if (ring_next(rx_wr) == rx_rd) return 1'b1;
        rx_fifo[rx_wr] = v;
        rx_wr = ring_next(rx_wr);
        return 1'b0;
    endfunction

    function automatic bit tx_enqueue(logic [7:0] v);
        if (ring_next(tx_wr) == tx_rd) return 1'b1;
        tx_fifo[tx_wr] = v;
        tx_wr = ring_next(tx_wr);
        return 1'b0;
    endfunction

    // Receive data has priority over transmitter empty; only a promotion raises the line.
    function automatic void raise_int(logic [1:0] src);
        logic [1:0] active;
        logic       promoted;
        int_src  = int_src | src;
        active   = int_src & ier[1:0];
        promoted = 1'b0;
        if (active[0] && iir < IIR_RDA) begin
            iir = IIR_RDA;
            promoted = 1'b1;
        end else if (active[1] && iir < IIR_THRE) begin
            iir = IIR_THRE;
            promoted = 1'b1;
        end
        if (promoted && mcr[3]) irq_seen = 1'b1;
    endfunction

    function automatic void drop_int(logic [1:0] src);
        int_src = int_src & ~src;
        if (src[0] && iir == IIR_RDA) iir = IIR_NONE;
        if (src[1] && iir == IIR_THRE) iir = IIR_NONE;
        raise_int(INT_NONE);
    endfunction

    function automatic void load_rbr();
        if (rbr_full || rx_rd == rx_wr) return;
        rbr = rx_fifo[rx_rd];
        rx_rd = ring_next(rx_rd);
        rbr_full = 1'b1;
        lsr = lsr | LSR_DR;
        rx_load_seen = 1'b1;
        raise_int(INT_RX);
    endfunction

    // In loopback the byte goes to the receive queue and is dropped when that is full.
    function automatic void drain_thr();
        if (!thr_full) return;
        if (mcr[4]) begin
            void'(rx_enqueue(thr));
        end else if (tx_enqueue(thr)) begin
            return;
        end
        thr_full = 1'b0;
        lsr = lsr | LSR_THRE;
        if (mcr[4]) begin
            load_rbr();
        end else begin
            tx_send_seen = 1'b1;
        end
        raise_int(INT_TX);
    endfunction

    function automatic void line_change(logic [7:0] line_bit, logic [7:0] delta_bit, logic lvl);
        logic [7:0] old;
        old = msr;
        msr = lvl ? (msr | line_bit) : (msr & ~line_bit);
        if (((old ^ msr) & line_bit) != 8'h00) msr = msr | delta_bit;
    endfunction

    function automatic void mcr_write(logic [7:0] v);
        logic [7:0] old;
        if (mcr[4] && !v[4]) begin
            old = msr;
            msr = msr & MSR_DELTA_MASK;
            msr = msr | (((old ^ msr) & ~(msr & MSR_RI)) >> 4);
            setup_seen = 1'b1;
        end
        mcr = v[4:0];
        if (v[4]) begin
            old = msr;
            msr = msr & MSR_DELTA_MASK;
            if (v[1]) msr = msr | MSR_CTS;
            if (v[0]) msr = msr | MSR_DSR;
            if (v[2]) msr = msr | MSR_RI;
            if (v[3]) msr = msr | MSR_DCD;
            msr = msr | (((old ^ msr) & ~(msr & MSR_RI)) >> 4);
            setup_seen = 1'b1;
        end
    endfunction

    function automatic logic [7:0] reg_read(logic [2:0] a);
        logic [7:0] v;
        logic       dlab;
        dlab = lcr[7];
        case (a)
            REG_DATA: begin
                if (dlab) return divisor_latch[7:0];
                v = rbr;
                rbr_full = 1'b0;
                lsr = lsr & ~LSR_DR;
                drop_int(INT_RX);
                load_rbr();
                return v;
            end
            REG_IER: return dlab ? divisor_latch[15:8] : {4'h0, ier};
            REG_IIR: begin
                v = {5'b0, iir};
                drop_int(INT_TX);
                return v;
            end
            REG_LCR: return lcr;
            REG_MCR: return {3'b0, mcr};
            REG_LSR: return lsr;
            REG_MSR: begin
                v = msr;
                msr = msr & MSR_LINE_MASK;
                return v;
            end
            default: return scr;
        endcase
    endfunction

    function automatic void reg_write(logic [2:0] a, logic [7:0] v);
        logic dlab;
        dlab = lcr[7];
        case (a)
            REG_DATA: begin
                if (dlab) begin
                    divisor_latch[7:0] = v;
                    setup_seen = 1'b1;
                end else begin
                    thr = v;
                    thr_full = 1'b1;
                    lsr = lsr & ~LSR_THRE;
                    drop_int(INT_TX);
                    drain_thr();
                end
            end
            REG_IER: begin
                if (dlab) begin
                    divisor_latch[15:8] = v;
                    setup_seen = 1'b1;
                end else begin
                    ier = v[3:0];
                    raise_int({lsr[5], lsr[0]});
                end
            end
            REG_LCR: begin
                lcr = v;
                setup_seen = 1'b1;
            end
            REG_MCR: mcr_write(v);
            REG_SCR: scr = v;
            default: ;
        endcase
    endfunction

    function automatic uart_reply_t predict_reply(action_t act, logic [2:0] addr,
                                                  logic [7:0] wdata, logic lvl);
        uart_reply_t r;
        r = '0;
        irq_seen = 1'b0;
        rx_load_seen = 1'b0;
        tx_send_seen = 1'b0;
        setup_seen = 1'b0;
        case (act)
            ACT_READ:  r.rdata = reg_read(addr);
            ACT_WRITE: reg_write(addr, wdata);
            ACT_TICK: begin
                load_rbr();
                drain_thr();
            end
            ACT_PUSH:  r.queue_fail = rx_enqueue(wdata);
            ACT_PULL: begin
                if (tx_rd == tx_wr) begin
                    r.queue_fail = 1'b1;
                end else begin
                    r.tx_byte = tx_fifo[tx_rd];
                    tx_rd = ring_next(tx_rd);
                end
            end
            ACT_DSR:   line_change(MSR_DSR, MSR_DDSR, lvl);
            ACT_CTS:   line_change(MSR_CTS, MSR_DCTS, lvl);
            default:   line_change(MSR_DCD, MSR_DDCD, lvl);
        endcase
        r.irq_raise     = irq_seen;
        r.rx_loaded     = rx_load_seen;
        r.tx_sent       = tx_send_seen;
        r.setup_changed = setup_seen;
        r.dtr           = mcr[0];
        r.rts           = mcr[1];
        r.divisor       = divisor_latch;
        r.lcr           = lcr;
        return r;
    endfunction

    function automatic void clear_shadow();
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            rx_fifo[i] = 8'h00;
            tx_fifo[i] = 8'h00;
        end
        rx_rd = 0;
        rx_wr = 0;
        tx_rd = 0;
        tx_wr = 0;
        rbr = 8'h00;
        rbr_full = 1'b0;
        thr = 8'h00;
        thr_full = 1'b0;
        ier = 4'h0;
        iir = IIR_NONE;
        int_src = INT_NONE;
        lcr = 8'h00;
        lsr = LSR_RESET;
        mcr = 5'h00;
        msr = 8'h00;
        scr = 8'h00;
        divisor_latch = 16'h0000;
    endfunction

    task automatic report_mismatch(string what, int unsigned got, int unsigned want);
        fail_count++;
        $display("reply %0d: %s is 0x%0h, predicted 0x%0h", reply_num, what, got, want);
    endtask

    task automatic compare_reply(logic [47:0] d);
        uart_reply_t want;
        if (predicted_replies.size() == 0) begin
            report_mismatch("reply with nothing pending, low bits", d[31:0], 0);
            return;
        end
        want = predicted_replies.pop_front();
        if (d[7:0] !== want.rdata) report_mismatch("rdata", d[7:0], want.rdata);
        if (d[8] !== want.queue_fail) report_mismatch("queue_fail", d[8], want.queue_fail);
        if (d[16:9] !== want.tx_byte) report_mismatch("tx_byte", d[16:9], want.tx_byte);
        if (d[17] !== want.irq_raise) report_mismatch("irq_raise", d[17], want.irq_raise);
        if (d[18] !== want.rx_loaded) report_mismatch("rx_loaded", d[18], want.rx_loaded);
        if (d[19] !== want.tx_sent) report_mismatch("tx_sent", d[19], want.tx_sent);
        if (d[20] !== want.setup_changed) begin
            report_mismatch("setup_changed", d[20], want.setup_changed);
        end
        if (d[21] !== want.dtr) report_mismatch("dtr", d[21], want.dtr);
        if (d[22] !== want.rts) report_mismatch("rts", d[22], want.rts);
        if (d[38:23] !== want.divisor) report_mismatch("divisor_out", d[38:23], want.divisor);
        if (d[46:39] !== want.lcr) report_mismatch("line_control_out", d[46:39], want.lcr);
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            clear_shadow();
            predicted_replies.delete();
            reply_num = 0;
            fail_count = 0;
            outstanding <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                compare_reply(m_tdata);
                reply_num++;
            end
            if (s_tvalid && s_tready) begin
                predicted_replies.push_back(predict_reply(action_t'(s_tuser), s_tdata[2:0],
                                                          s_tdata[10:3], s_tdata[11]));
            end
            outstanding <= predicted_replies.size();
        end
    end

endmodule

/* test/tb_uart_8250_register_model.sv */
// Top of the testbench for the 8250 UART register model: clock, reset, request and
// reply traffic, and the verdict. Depends on uart8250_pkg, uart8250_reply_checker and uart_8250_register_model.
module tb_uart_8250_register_model
    import uart8250_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [15:0] s_tdata = '0;
    logic [2:0]  s_tuser = '0;
    logic        m_tready = 1'b0;
    wire         s_tready;
    wire         m_tvalid;
    wire  [47:0] m_tdata;
    int          fail_count;
    int          outstanding;

    // Requests accepted by the block and replies taken from it, counted by the
    // two driving processes; they also shape the idle patterns.
    int          requests_sent = 0;
    int          replies_taken = 0;

    uart_8250_register_model #(.QUEUE_SLOTS(2)) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    uart8250_reply_checker reply_check (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Offers one request and returns at the edge where it is accepted. Before it,
    // the sender idles for a random number of cycles, except in the first fifth of
    // every hundred requests, where requests follow back to back.
    task automatic send_request(action_t act, logic [2:0] addr, logic [7:0] wdata, logic lvl);
        int gap;
        gap = (requests_sent % 100 < 20) ? 0 : $urandom_range(0, 17);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {4'h0, lvl, wdata, addr};
        do @(posedge aclk); while (!s_tready);
        requests_sent++;
    endtask

    // Bus accesses; the fields that the access does not use still carry random bits.
    task automatic bus_read(logic [2:0] addr);
        send_request(ACT_READ, addr, 8'($urandom), 1'($urandom));
    endtask

    task automatic bus_write(logic [2:0] addr, logic [7:0] v);
        send_request(ACT_WRITE, addr, v, 1'($urandom));
    endtask

    // Host-side events: ticks, queue pushes and pulls, and modem line changes.
    task automatic host_event(action_t act, logic [7:0] v, logic lvl);
        send_request(act, 3'($urandom), v, lvl);
    endtask

    // One short, well-formed register sequence with random content, or a few
    // entirely random requests now and then.
    task automatic run_sequence();
        case ($urandom_range(0, 9))
            0, 1: begin
                // Transmit path: write the holding register, maybe tick, then pull.
                bus_write(REG_DATA, 8'($urandom));
                if ($urandom_range(0, 1) == 1) host_event(ACT_TICK, 8'($urandom), 1'($urandom));
                repeat ($urandom_range(1, 2)) host_event(ACT_PULL, 8'($urandom), 1'($urandom));
            end
            2, 3: begin
                // Receive path: the host pushes, a tick loads the holding register,
                // and the driver polls the status and reads the byte.
                repeat ($urandom_range(1, 2)) host_event(ACT_PUSH, 8'($urandom), 1'($urandom));
                host_event(ACT_TICK, 8'($urandom), 1'($urandom));
                bus_read(REG_LSR);
                bus_read(REG_DATA);
                if ($urandom_range(0, 1) == 1) bus_read(REG_IIR);
            end
            4: begin
                // Interrupt setup with OUT2 random, loopback kept off.
                bus_write(REG_IER, 8'($urandom));
                bus_write(REG_MCR, 8'($urandom) & 8'hef);
                bus_read(REG_IIR);
                bus_read(REG_IIR);
            end
            5: begin
                // Divisor latch programming under DLAB, then DLAB cleared again.
                bus_write(REG_LCR, 8'($urandom) | 8'h80);
                bus_write(REG_DATA, 8'($urandom));
                bus_write(REG_IER, 8'($urandom));
                bus_read(REG_DATA);
                bus_read(REG_IER);
                bus_write(REG_LCR, 8'($urandom) & 8'h7f);
            end
            6: begin
                // Loopback round trip and exit, with a line change in between.
                bus_write(REG_MCR, 8'($urandom) | 8'h10);
                bus_write(REG_DATA, 8'($urandom));
                host_event(ACT_TICK, 8'($urandom), 1'($urandom));
                host_event(action_t'($urandom_range(5, 7)), 8'($urandom), 1'($urandom));
                bus_read(REG_DATA);
                bus_read(REG_MSR);
                bus_write(REG_MCR, 8'($urandom) & 8'hef);
                bus_read(REG_MSR);
            end
            7: begin
                // Modem input changes followed by a status read that clears the deltas.
                repeat ($urandom_range(1, 3)) begin
                    host_event(action_t'($urandom_range(5, 7)), 8'($urandom), 1'($urandom));
                end
                bus_read(REG_MSR);
            end
            8: begin
                // Scratch register, writes to ignored offsets and plain register reads.
                bus_write(REG_SCR, 8'($urandom));
                bus_read(REG_SCR);
                bus_write(3'($urandom_range(0, 1) == 1 ? REG_IIR : REG_MSR), 8'($urandom));
                bus_write(REG_LSR, 8'($urandom));
                bus_read(REG_LSR);
                bus_read(REG_MCR);
                bus_read(REG_LCR);
            end
            default: begin
                repeat ($urandom_range(1, 3)) begin
                    send_request(action_t'($urandom_range(0, 7)), 3'($urandom), 8'($urandom),
                                 1'($urandom));
                end
            end
        endcase
    endtask

    // Reply side: a random stall before each reply, no stalls in part of every
    // ninety replies, and once a long hold-off so the block backs up and stops
    // accepting requests while the sender keeps offering them.
    initial begin
        int stall;
        wait (aresetn);
        @(posedge aclk);
        forever begin
            if (replies_taken == 400) begin
                stall = 80;
            end else if (replies_taken % 90 < 20) begin
                stall = 0;
            end else begin
                stall = $urandom_range(0, 17);
            end
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            replies_taken++;
        end
    end

    // Guard against a hung handshake; the slowest correct run stays far below this.
    initial begin
        #5ms;
        $display("status: fail");
        $finish;
    end

    initial begin
        int waited;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed part. Reset values of the interrupt, line and modem status.
        bus_read(REG_IIR);
        bus_read(REG_LSR);
        bus_read(REG_MSR);
        // Enable every interrupt source; the empty transmitter becomes pending.
        bus_write(REG_IER, 8'hff);
        // Turn on OUT2, RTS and DTR so that new interrupts show up as raises.
        bus_write(REG_MCR, 8'h0b);
        bus_read(REG_IIR);
        // The first byte moves to the transmit queue; the second stays in the
        // holding register because the queue has room for one byte only.
        bus_write(REG_DATA, 8'hff);
        bus_write(REG_DATA, 8'h00);
        // The second push hits a full receive queue.
        host_event(ACT_PUSH, 8'h00, 1'b0);
        host_event(ACT_PUSH, 8'hff, 1'b1);
        host_event(ACT_TICK, 8'h00, 1'b0);
        host_event(ACT_PULL, 8'hff, 1'b1);
        host_event(ACT_TICK, 8'hff, 1'b1);
        host_event(ACT_PULL, 8'h00, 1'b0);
        // Pull from an empty transmit queue.
        host_event(ACT_PULL, 8'h00, 1'b0);
        bus_read(REG_DATA);
        // Read of the receive register with nothing new in it.
        bus_read(REG_DATA);
        // Loopback with every modem output set: the byte comes straight back,
        // line events still reach the status, and leaving loopback records deltas.
        bus_write(REG_MCR, 8'h1f);
        bus_write(REG_DATA, 8'ha5);
        host_event(ACT_DSR, 8'h00, 1'b1);
        host_event(ACT_CTS, 8'hff, 1'b0);
        host_event(ACT_DCD, 8'h00, 1'b1);
        bus_write(REG_MCR, 8'h00);
        bus_read(REG_MSR);
        // Divisor latch at its largest value, then DLAB off again.
        bus_write(REG_LCR, 8'h80);
        bus_write(REG_DATA, 8'hff);
        bus_write(REG_IER, 8'hff);
        bus_read(REG_DATA);
        bus_read(REG_IER);
        bus_write(REG_LCR, 8'h7f);
        // Scratch at its top value and writes to read-only offsets.
        bus_write(REG_SCR, 8'hff);
        bus_write(REG_IIR, 8'hff);
        bus_write(REG_LSR, 8'hff);
        bus_write(REG_MSR, 8'hff);

        // Random part.
        while (requests_sent < 950) run_sequence();
        s_tvalid <= 1'b0;

        // Wait for the outstanding replies, then idle on to catch anything stray.
        waited = 0;
        do begin
            @(posedge aclk);
            waited++;
        end while (outstanding != 0 && waited < 4000);
        repeat (8) @(posedge aclk);

        if (fail_count == 0 && outstanding == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
